### design/hpse_pkg.sv
// Shared types and constants for the H.264 parameter set extractor.
// No dependencies; used by the top level and its port checker.
package hpse_pkg;

  // Default buffer limit in bytes
  localparam int MAX_BYTES_DEF = 4096;

  // Result field widths
  localparam int OFF_W    = 12;
  localparam int LEN_W    = 13;
  localparam int LAYOUT_W = 2;

  // NAL header decode
  localparam logic [7:0] START_CODE_END = 8'h01;
  localparam logic [4:0] NAL_SPS        = 5'd7;
  localparam logic [4:0] NAL_PPS        = 5'd8;

  // Layout of the extradata buffer
  typedef enum logic [LAYOUT_W-1:0] {
    LAYOUT_ANNEXB = 2'd0,
    LAYOUT_AVCC   = 2'd1,
    LAYOUT_BARE   = 2'd2,
    LAYOUT_NONE   = 2'd3
  } layout_t;

endpackage

### design/h264_param_set_extractor.sv
// H.264 parameter set extractor: scans codec extradata for the first SPS and PPS.
// Depends on hpse_pkg for field widths, NAL codes and layout codes.
//
// Usage: extradata enters one byte per request on the in_ channel (valid/ready),
// with in_last set on the final byte of a buffer. Two parsers run side by side:
// an Annex-B start code scanner and a 4-byte big-endian length prefix walker.
// After the last byte one result request leaves on the out_ channel with the
// offset and length of the first SPS and PPS, the layout that supplied them and
// an overflow flag (buffer longer than MAX_BYTES; extra bytes are ignored).
// Non-final bytes produce no result.
// Throughput: one byte per cycle, except for the stall below. A byte is held in an
// input register, then the parser state and the result register update from it.
// Stall: while a result waits on out_ready, non-final bytes of the next buffer
// still flow; only a second final byte waits in the input register.
// Reset (rst_n low, synchronous) clears the parsers and drops any held request.
// After each final byte the parsers return to the reset state on their own.
module h264_param_set_extractor #(
  parameter int MAX_BYTES = hpse_pkg::MAX_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_sps_found,
  output logic [hpse_pkg::OFF_W-1:0]    out_sps_offset,
  output logic [hpse_pkg::LEN_W-1:0]    out_sps_length,
  output logic                          out_pps_found,
  output logic [hpse_pkg::OFF_W-1:0]    out_pps_offset,
  output logic [hpse_pkg::LEN_W-1:0]    out_pps_length,
  output logic [hpse_pkg::LAYOUT_W-1:0] out_layout,
  output logic                          out_overflow
);

  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam int OW = hpse_pkg::OFF_W;
  localparam int LW = hpse_pkg::LEN_W;

  typedef logic [CW-1:0] cnt_t;
  typedef logic [CW+1:0] cntx_t;

  typedef struct packed {
    logic found;
    cnt_t off;
    cnt_t len;
  } span_t;

  typedef struct packed {
    span_t sps;
    span_t pps;
  } sets_t;

  localparam cnt_t  CNT_MAX   = cnt_t'(MAX_BYTES);
  localparam cnt_t  PFX_BYTES = cnt_t'(4);
  localparam cnt_t  PFX_LAST  = cnt_t'(3);
  localparam sets_t SETS_NONE = '0;

  // Record a unit as the first SPS or PPS if nothing of its kind is held yet
  function automatic sets_t take_unit(sets_t s, logic en, logic [4:0] kind,
                                      cnt_t off, cnt_t len);
    sets_t r;
    r = s;
    if (en && len != '0) begin
      if (kind == hpse_pkg::NAL_SPS && !s.sps.found) begin
        r.sps = '{found: 1'b1, off: off, len: len};
      end else if (kind == hpse_pkg::NAL_PPS && !s.pps.found) begin
        r.pps = '{found: 1'b1, off: off, len: len};
      end
    end
    return r;
  endfunction

  // Input register
  logic       s_valid_r;
  logic [7:0] s_data_r;
  logic       s_last_r;
  logic       fire;

  // Parser state
  logic [7:0] win_r [0:2];
  logic [7:0] win_nxt [0:2];
  cnt_t        byte_cnt_r, byte_cnt_nxt;
  logic        in_unit_r, in_unit_nxt;
  cnt_t        unit_start_r, unit_start_nxt;
  logic [4:0]  unit_kind_r, unit_kind_nxt;
  sets_t       sc_r, sc_nxt;
  cnt_t        pfx_ptr_r, pfx_ptr_nxt;
  logic [31:0] pfx_len_r, pfx_len_nxt;
  logic [4:0]  pfx_kind_r, pfx_kind_nxt;
  logic        pfx_halt_r, pfx_halt_nxt;
  sets_t       pfx_r, pfx_nxt;
  logic        first_sps_r, first_sps_nxt;
  logic        ovf_r, ovf_nxt;

  // Scan and result helpers
  logic        consume;
  cntx_t       kx, usx;
  logic        sc_hit;
  cnt_t        sc_q;
  cnt_t        rel;
  logic [31:0] pfx_shift;
  logic [4:0]  pfx_kind_eff;
  sets_t       fin;
  span_t       res_sps, res_pps;
  hpse_pkg::layout_t res_layout;

  // Result register
  logic                          out_valid_r;
  logic                          out_sps_found_r, out_pps_found_r;
  logic [OW-1:0]                 out_sps_offset_r, out_pps_offset_r;
  logic [LW-1:0]                 out_sps_length_r, out_pps_length_r;
  logic [hpse_pkg::LAYOUT_W-1:0] out_layout_r;
  logic                          out_overflow_r;

  // Advance the held byte unless it is final and the result slot is still full
  assign fire     = s_valid_r && (!s_last_r || !out_valid_r || out_ready);
  assign in_ready = !s_valid_r || fire;

  // Per-byte parser update
  always_comb begin
    consume        = byte_cnt_r < CNT_MAX;
    kx             = {2'b00, byte_cnt_r};
    usx            = {2'b00, unit_start_r};
    sc_hit         = s_data_r == hpse_pkg::START_CODE_END && win_r[0] == 8'h00 &&
                     win_r[1] == 8'h00 && kx >= usx + cntx_t'(2);
    sc_q           = (kx >= usx + cntx_t'(3) && win_r[2] == 8'h00) ?
                     byte_cnt_r - cnt_t'(3) : byte_cnt_r - cnt_t'(2);
    rel            = byte_cnt_r - pfx_ptr_r;
    pfx_shift      = {pfx_len_r[23:0], s_data_r};
    pfx_kind_eff   = (rel == PFX_BYTES) ? s_data_r[4:0] : pfx_kind_r;

    win_nxt        = win_r;
    byte_cnt_nxt   = byte_cnt_r;
    in_unit_nxt    = in_unit_r;
    unit_start_nxt = unit_start_r;
    unit_kind_nxt  = unit_kind_r;
    sc_nxt         = sc_r;
    pfx_ptr_nxt    = pfx_ptr_r;
    pfx_len_nxt    = pfx_len_r;
    pfx_kind_nxt   = pfx_kind_r;
    pfx_halt_nxt   = pfx_halt_r;
    pfx_nxt        = pfx_r;
    first_sps_nxt  = first_sps_r;
    ovf_nxt        = ovf_r;

    if (consume) begin
      if (byte_cnt_r == '0) begin
        first_sps_nxt = s_data_r[4:0] == hpse_pkg::NAL_SPS;
      end

      // Start code scanner: latch the NAL type, close a unit on each start code
      if (in_unit_r && byte_cnt_r == unit_start_r) begin
        unit_kind_nxt = s_data_r[4:0];
      end
      if (sc_hit) begin
        sc_nxt = take_unit(sc_r, in_unit_r && sc_q > unit_start_r, unit_kind_r,
                           unit_start_r, sc_q - unit_start_r);
        unit_start_nxt = byte_cnt_r + cnt_t'(1);
        in_unit_nxt    = 1'b1;
      end
      win_nxt[2] = win_r[1];
      win_nxt[1] = win_r[0];
      win_nxt[0] = s_data_r;

      // Length prefix walker: gather the prefix, then wait for the unit end
      if (!pfx_halt_r) begin
        if (rel < PFX_BYTES) begin
          pfx_len_nxt = pfx_shift;
          if (rel == PFX_LAST && pfx_shift == 32'd0) begin
            pfx_halt_nxt = 1'b1;
          end
        end else begin
          pfx_kind_nxt = pfx_kind_eff;
          if (32'(rel) - 32'd3 == pfx_len_r) begin
            pfx_nxt = take_unit(pfx_r, 1'b1, pfx_kind_eff, pfx_ptr_r + PFX_BYTES,
                                cnt_t'(pfx_len_r));
            pfx_ptr_nxt = byte_cnt_r + cnt_t'(1);
            pfx_len_nxt = 32'd0;
          end
        end
      end

      byte_cnt_nxt = byte_cnt_r + cnt_t'(1);
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  // Close the open unit at buffer end and pick the winning layout
  always_comb begin
    fin = take_unit(sc_nxt, in_unit_nxt && byte_cnt_nxt > unit_start_nxt,
                    unit_kind_nxt, unit_start_nxt, byte_cnt_nxt - unit_start_nxt);
    res_sps = '0;
    res_pps = '0;
    if (fin.sps.found || fin.pps.found) begin
      res_sps    = fin.sps;
      res_pps    = fin.pps;
      res_layout = hpse_pkg::LAYOUT_ANNEXB;
    end else if (pfx_nxt.sps.found || pfx_nxt.pps.found) begin
      res_sps    = pfx_nxt.sps;
      res_pps    = pfx_nxt.pps;
      res_layout = hpse_pkg::LAYOUT_AVCC;
    end else if (first_sps_nxt) begin
      res_sps    = '{found: 1'b1, off: '0, len: byte_cnt_nxt};
      res_layout = hpse_pkg::LAYOUT_BARE;
    end else begin
      res_layout = hpse_pkg::LAYOUT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      win_r        <= '{default: 8'h00};
      byte_cnt_r   <= '0;
      in_unit_r    <= 1'b0;
      unit_start_r <= '0;
      unit_kind_r  <= '0;
      sc_r         <= SETS_NONE;
      pfx_ptr_r    <= '0;
      pfx_len_r    <= '0;
      pfx_kind_r   <= '0;
      pfx_halt_r   <= 1'b0;
      pfx_r        <= SETS_NONE;
      first_sps_r  <= 1'b0;
      ovf_r        <= 1'b0;
    end else begin
      // Input register: load on accept, drop once advanced
      if (in_valid && in_ready) begin
        s_valid_r <= 1'b1;
        s_data_r  <= in_data_byte;
        s_last_r  <= in_last;
      end else if (fire) begin
        s_valid_r <= 1'b0;
      end

      // Result register: load on a final byte, hold until taken
      if (fire && s_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (fire) begin
        if (s_last_r) begin
          out_sps_found_r  <= res_sps.found;
          out_sps_offset_r <= OW'(res_sps.off);
          out_sps_length_r <= LW'(res_sps.len);
          out_pps_found_r  <= res_pps.found;
          out_pps_offset_r <= OW'(res_pps.off);
          out_pps_length_r <= LW'(res_pps.len);
          out_layout_r     <= res_layout;
          out_overflow_r   <= ovf_nxt;
          // Start the next buffer from a clean state
          win_r        <= '{default: 8'h00};
          byte_cnt_r   <= '0;
          in_unit_r    <= 1'b0;
          unit_start_r <= '0;
          unit_kind_r  <= '0;
          sc_r         <= SETS_NONE;
          pfx_ptr_r    <= '0;
          pfx_len_r    <= '0;
          pfx_kind_r   <= '0;
          pfx_halt_r   <= 1'b0;
          pfx_r        <= SETS_NONE;
          first_sps_r  <= 1'b0;
          ovf_r        <= 1'b0;
        end else begin
          win_r        <= win_nxt;
          byte_cnt_r   <= byte_cnt_nxt;
          in_unit_r    <= in_unit_nxt;
          unit_start_r <= unit_start_nxt;
          unit_kind_r  <= unit_kind_nxt;
          sc_r         <= sc_nxt;
          pfx_ptr_r    <= pfx_ptr_nxt;
          pfx_len_r    <= pfx_len_nxt;
          pfx_kind_r   <= pfx_kind_nxt;
          pfx_halt_r   <= pfx_halt_nxt;
          pfx_r        <= pfx_nxt;
          first_sps_r  <= first_sps_nxt;
          ovf_r        <= ovf_nxt;
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sps_found  = out_sps_found_r;
  assign out_sps_offset = out_sps_offset_r;
  assign out_sps_length = out_sps_length_r;
  assign out_pps_found  = out_pps_found_r;
  assign out_pps_offset = out_pps_offset_r;
  assign out_pps_length = out_pps_length_r;
  assign out_layout     = out_layout_r;
  assign out_overflow   = out_overflow_r;

endmodule

### design/hpse_checker.sv
// Port-level checks for the H.264 parameter set extractor, bound to its top level.
// Depends on hpse_pkg for field widths and layout codes.
module hpse_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_sps_found,
  input logic [hpse_pkg::OFF_W-1:0]    out_sps_offset,
  input logic [hpse_pkg::LEN_W-1:0]    out_sps_length,
  input logic                          out_pps_found,
  input logic [hpse_pkg::OFF_W-1:0]    out_pps_offset,
  input logic [hpse_pkg::LEN_W-1:0]    out_pps_length,
  input logic [hpse_pkg::LAYOUT_W-1:0] out_layout,
  input logic                          out_overflow
);

  // Nothing found means neither set is flagged
  a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_layout == hpse_pkg::LAYOUT_NONE |-> !out_sps_found && !out_pps_found)
    else $error("nothing-found layout flags a parameter set");

  // A bare SPS is the whole buffer from offset zero, with no PPS
  a_bare_sps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_layout == hpse_pkg::LAYOUT_BARE |->
      out_sps_found && out_sps_offset == '0 && !out_pps_found)
    else $error("bare SPS layout with bad fields");

  // A parsed layout is only reported when it located at least one set
  a_parsed_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_layout == hpse_pkg::LAYOUT_ANNEXB ||
                  out_layout == hpse_pkg::LAYOUT_AVCC) |->
      out_sps_found || out_pps_found)
    else $error("parsed layout without any parameter set");

  // Sets not found carry zero offset and length
  a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_sps_found || (out_sps_offset == '0 && out_sps_length == '0)) &&
      (out_pps_found || (out_pps_offset == '0 && out_pps_length == '0)))
    else $error("missing parameter set with nonzero span");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_sps_found, out_sps_offset, out_sps_length, out_pps_found,
               out_pps_offset, out_pps_length, out_layout, out_overflow}))
    else $error("result changed while stalled");

endmodule

bind h264_param_set_extractor hpse_checker u_hpse_checker (.*);
